// ----- rtl/core/cti_pkg.sv -----
// Package for the complex tridiagonal inverter: Q16.16 complex types and constants.
// No dependencies; used by every other file of the block but the checker.
package cti_pkg;
	typedef struct packed {
		logic signed [31:0] re;
		logic signed [31:0] im;
	} cpx_t;

	typedef struct packed {
		logic [31:0] diag_re;
		logic [31:0] diag_im;
		logic [31:0] upper_re;
		logic [31:0] upper_im;
		logic [31:0] lower_re;
		logic [31:0] lower_im;
	} row_req_t;

	typedef struct packed {
		logic [2:0]  row;
		logic [2:0]  col;
		logic [31:0] value_re;
		logic [31:0] value_im;
		logic        singular;
		logic        last_result;
	} elem_t;

	// Queue entry from the loader to the solver.
	typedef struct packed {
		cpx_t       diag;
		cpx_t       upper;
		cpx_t       lower;
		logic [2:0] idx;
		logic       last;
		logic [3:0] size;
	} task_t;

	localparam logic signed [31:0] ONE_Q16 = 32'sd65536;
	localparam logic [3:0] SIZE_RESET = 4'd5;
endpackage

// ----- rtl/core/cti_if.sv -----
// Valid/ready channel interfaces for the complex tridiagonal inverter.
// Depends on cti_pkg for the payload structs.
interface cti_row_if;
	logic               valid;
	logic               ready;
	cti_pkg::row_req_t  data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface cti_elem_if;
	logic           valid;
	logic           ready;
	cti_pkg::elem_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/core/cti_front.sv -----
// Front end: accepts row requests, tracks the row index and pushes tagged rows.
// Depends on cti_pkg.
module cti_front #(
	parameter int MAX_SIZE = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [3:0]         cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  cti_pkg::row_req_t  in_data,
	output logic               push,
	output cti_pkg::task_t     push_data,
	input  logic               q_full
);
	import cti_pkg::*;
	localparam int IW = $clog2(MAX_SIZE);

	logic [3:0]    size_q;
	logic [2:0]    row_q;
	logic [3:0]    n_eff;

	always_comb begin
		if (size_q < 4'd2) begin
			n_eff = 4'd2;
		end else if (size_q > 4'(MAX_SIZE)) begin
			n_eff = 4'(MAX_SIZE);
		end else begin
			n_eff = size_q;
		end
	end

	assign in_ready = !q_full;
	assign push = in_valid && in_ready;
	always_comb begin
		push_data.diag  = '{re: in_data.diag_re, im: in_data.diag_im};
		push_data.upper = '{re: in_data.upper_re, im: in_data.upper_im};
		push_data.lower = '{re: in_data.lower_re, im: in_data.lower_im};
		push_data.idx   = row_q;
		push_data.last  = ({1'b0, row_q} + 4'd1) >= n_eff;
		push_data.size  = n_eff;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= SIZE_RESET;
			row_q  <= '0;
		end else if (cfg_we) begin
			size_q <= cfg_data;
			row_q  <= '0;
		end else if (push) begin
			row_q <= push_data.last ? 3'd0 : 3'(IW'(row_q + 3'd1));
		end
	end
endmodule

// ----- rtl/core/cti_queue.sv -----
// Short FIFO between front and back of the inverter.
// Depends on cti_pkg for the entry type.
module cti_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  cti_pkg::task_t push_data,
	output logic           full,
	input  logic           pop,
	output logic           empty,
	output cti_pkg::task_t pop_data
);
	import cti_pkg::*;
	task_t       mem_q [2];
	logic        wp_q, rp_q;
	logic [1:0]  cnt_q;

	assign full = cnt_q == 2'd2;
	assign empty = cnt_q == 2'd0;
	assign pop_data = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (pop) rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end
endmodule

// ----- rtl/core/cti_div.sv -----
// Iterative fixed-point complex divider: one quotient bit of each part per cycle.
// Depends on cti_pkg.
module cti_div (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  cti_pkg::cpx_t num,
	input  cti_pkg::cpx_t den,
	output logic          done,
	output logic          zero_den,
	output cti_pkg::cpx_t quo
);
	import cti_pkg::*;
	typedef enum logic [1:0] {D_IDLE, D_PREP, D_RUN} dstate_t;

	dstate_t       st_q;
	logic [63:0]   den_q;
	logic [63:0]   mr_q, mi_q;
	logic          nr_q, ni_q;
	logic [64:0]   rr_q, ri_q;
	logic [48:0]   qr_q, qi_q;
	logic [6:0]    cnt_q;
	logic signed [63:0] p1, p2, p3, p4;
	logic signed [64:0] sr, si;
	logic [64:0]   tr, ti;

	always_comb begin
		p1 = num.re * den.re;
		p2 = num.im * den.im;
		p3 = num.im * den.re;
		p4 = num.re * den.im;
		sr = 65'(p1) + 65'(p2);
		si = 65'(p3) - 65'(p4);
		tr = {rr_q[63:0], mr_q[63]};
		ti = {ri_q[63:0], mi_q[63]};
	end

	function automatic logic [31:0] fin(input logic neg, input logic [48:0] q);
		logic [31:0] r;
		if (q[48:32] != '0) begin
			r = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
		end else if (!neg) begin
			r = q[31] ? 32'h7FFF_FFFF : q[31:0];
		end else if (q[31:0] > 32'h8000_0000) begin
			r = 32'h8000_0000;
		end else begin
			r = 32'(-q[31:0]);
		end
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= D_IDLE;
			done <= 1'b0;
			zero_den <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			unique case (st_q)
				D_IDLE: begin
					if (start) begin
						den_q <= (64'(den.re) * 64'(den.re)) + (64'(den.im) * 64'(den.im));
						nr_q <= sr[64];
						ni_q <= si[64];
						mr_q <= sr[64] ? 64'(-sr) : sr[63:0];
						mi_q <= si[64] ? 64'(-si) : si[63:0];
						st_q <= D_PREP;
					end
				end
				D_PREP: begin
					if (den_q == '0) begin
						zero_den <= 1'b1;
						done <= 1'b1;
						st_q <= D_IDLE;
					end else begin
						zero_den <= 1'b0;
						rr_q <= '0;
						ri_q <= '0;
						qr_q <= '0;
						qi_q <= '0;
						cnt_q <= 7'd80;
						st_q <= D_RUN;
					end
				end
				D_RUN: begin
					// Restoring division over the 64 numerator bits plus 16 fraction bits.
					if (tr >= {1'b0, den_q}) begin
						rr_q <= tr - {1'b0, den_q};
						qr_q <= {qr_q[47:0], 1'b1};
					end else begin
						rr_q <= tr;
						qr_q <= {qr_q[47:0], 1'b0};
					end
					if (ti >= {1'b0, den_q}) begin
						ri_q <= ti - {1'b0, den_q};
						qi_q <= {qi_q[47:0], 1'b1};
					end else begin
						ri_q <= ti;
						qi_q <= {qi_q[47:0], 1'b0};
					end
					mr_q <= {mr_q[62:0], 1'b0};
					mi_q <= {mi_q[62:0], 1'b0};
					cnt_q <= cnt_q - 7'd1;
					if (cnt_q == 7'd1) begin
						st_q <= D_IDLE;
						done <= 1'b1;
					end
				end
				default: st_q <= D_IDLE;
			endcase
			if (st_q == D_RUN && cnt_q == 7'd0) begin
				st_q <= D_IDLE;
			end
		end
	end

	// Quotient bits above bit 48 only matter as overflow; track them sticky.
	logic ovr_q, ovi_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovr_q <= 1'b0;
			ovi_q <= 1'b0;
		end else if (st_q == D_PREP) begin
			ovr_q <= 1'b0;
			ovi_q <= 1'b0;
		end else if (st_q == D_RUN) begin
			ovr_q <= ovr_q | qr_q[48];
			ovi_q <= ovi_q | qi_q[48];
		end
	end

	always_comb begin
		if (zero_den) begin
			quo = '0;
		end else begin
			quo.re = fin(nr_q, {ovr_q | qr_q[48], qr_q[47:0]});
			quo.im = fin(ni_q, {ovi_q | qi_q[48], qi_q[47:0]});
		end
	end
endmodule

// ----- rtl/core/cti_back.sv -----
// Back end: stores rows, runs both ratio sweeps, diagonal and column propagation,
// then streams the inverse. Depends on cti_pkg and cti_div.
module cti_back #(
	parameter int MAX_SIZE = 8
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_empty,
	input  cti_pkg::task_t  q_data,
	output logic            pop,
	output logic            out_valid,
	input  logic            out_ready,
	output cti_pkg::elem_t  out_data
);
	import cti_pkg::*;
	localparam int IW = $clog2(MAX_SIZE);
	localparam int GW = 2 * IW;

	typedef enum logic [3:0] {
		S_IDLE, S_UP, S_UPW, S_UPM, S_DN, S_DNW, S_DNM,
		S_DG, S_DGW, S_CU, S_CD, S_CM, S_OUT
	} state_t;

	state_t         st_q;
	cpx_t           a_q [MAX_SIZE];
	cpx_t           b_q [MAX_SIZE];
	cpx_t           c_q [MAX_SIZE];
	cpx_t           ur_q [MAX_SIZE];
	cpx_t           dr_q [MAX_SIZE];
	cpx_t           xs_q [MAX_SIZE];
	cpx_t           ys_q [MAX_SIZE];
	cpx_t           gd_q [MAX_SIZE];
	cpx_t           g_q [2**GW];
	cpx_t           gv_q;
	logic [3:0]     n_q;
	logic [3:0]     k_q;
	logic [3:0]     m_q;
	logic [3:0]     cc_q;
	logic           sing_q;
	cpx_t           prev_q;
	cpx_t           mul_a, mul_b, mul_r, neg_r;
	logic           div_start;
	cpx_t           div_num, div_den, div_q;
	logic           div_done, div_zero;
	logic [IW-1:0]  oi_q, oj_q;
	logic [IW-1:0]  nxt_i, nxt_j;

	function automatic logic [31:0] sat_sub(input logic signed [31:0] x,
			input logic signed [31:0] y);
		logic signed [32:0] d;
		d = 33'(x) - 33'(y);
		if (d > 33'sd2147483647) return 32'h7FFF_FFFF;
		if (d < -33'sd2147483648) return 32'h8000_0000;
		return d[31:0];
	endfunction

	function automatic cpx_t csub(input cpx_t x, input cpx_t y);
		cpx_t r;
		r.re = sat_sub(x.re, y.re);
		r.im = sat_sub(x.im, y.im);
		return r;
	endfunction

	function automatic logic [31:0] flr(input logic signed [64:0] s);
		logic signed [48:0] q;
		q = s[64:16];
		if (q > 49'sd2147483647) return 32'h7FFF_FFFF;
		if (q < -49'sd2147483648) return 32'h8000_0000;
		return q[31:0];
	endfunction

	// Complex multiply; the product is registered in the S_UPM/S_DNM/S_CU/S_CD states.
	always_comb begin
		logic signed [63:0] p1, p2, p3, p4;
		p1 = mul_a.re * mul_b.re;
		p2 = mul_a.im * mul_b.im;
		p3 = mul_a.re * mul_b.im;
		p4 = mul_a.im * mul_b.re;
		mul_r.re = flr(65'(p1) - 65'(p2));
		mul_r.im = flr(65'(p3) + 65'(p4));
		neg_r.re = sat_sub(32'sd0, mul_r.re);
		neg_r.im = sat_sub(32'sd0, mul_r.im);
	end

	cti_div u_div (
		.clk, .arst_n, .start(div_start), .num(div_num), .den(div_den),
		.done(div_done), .zero_den(div_zero), .quo(div_q)
	);

	always_comb begin
		div_start = 1'b0;
		div_num = '0;
		div_den = '0;
		mul_a = '0;
		mul_b = '0;
		case (st_q)
			S_UP: begin
				div_start = 1'b1;
				div_num = b_q[IW'(k_q - 4'd1)];
				div_den = csub(a_q[IW'(k_q - 4'd1)], ys_q[IW'(k_q - 4'd1)]);
			end
			S_UPM: begin
				mul_a = c_q[IW'(k_q - 4'd1)];
				mul_b = ur_q[IW'(k_q)];
			end
			S_DN: begin
				div_start = 1'b1;
				div_num = c_q[IW'(k_q)];
				div_den = csub(a_q[IW'(k_q + 4'd1)], xs_q[IW'(k_q + 4'd1)]);
			end
			S_DNM: begin
				mul_a = b_q[IW'(k_q)];
				mul_b = dr_q[IW'(k_q)];
			end
			S_DG: begin
				div_start = 1'b1;
				div_num = '{re: ONE_Q16, im: 32'sd0};
				div_den = csub(csub(a_q[IW'(k_q)], xs_q[IW'(k_q)]), ys_q[IW'(k_q)]);
			end
			S_CU: begin
				mul_a = ur_q[IW'(m_q)];
				mul_b = prev_q;
			end
			S_CD: begin
				mul_a = dr_q[IW'(m_q)];
				mul_b = prev_q;
			end
			default: ;
		endcase
	end

	// Address of the element shown next; the inverse store is read in the cycle before, into gv_q.
	always_comb begin
		nxt_i = oi_q;
		nxt_j = oj_q;
		if (st_q == S_CD && m_q + 4'd1 >= n_q && cc_q + 4'd1 == n_q) begin
			nxt_i = '0;
			nxt_j = '0;
		end else if (st_q == S_OUT && out_ready) begin
			if ({1'b0, 4'(oj_q)} + 5'd1 == {1'b0, n_q}) begin
				nxt_j = '0;
				if ({1'b0, 4'(oi_q)} + 5'd1 == {1'b0, n_q}) begin
					nxt_i = '0;
				end else begin
					nxt_i = oi_q + IW'(1);
				end
			end else begin
				nxt_j = oj_q + IW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		gv_q <= g_q[{nxt_i, nxt_j}];
	end

	assign pop = (st_q == S_IDLE) && !q_empty;
	assign out_valid = st_q == S_OUT;
	always_comb begin
		out_data.row = 3'(oi_q);
		out_data.col = 3'(oj_q);
		out_data.value_re = gv_q.re;
		out_data.value_im = gv_q.im;
		out_data.singular = sing_q;
		out_data.last_result = ({1'b0, 4'(oi_q)} + 5'd1 == {1'b0, n_q})
			&& ({1'b0, 4'(oj_q)} + 5'd1 == {1'b0, n_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			sing_q <= 1'b0;
			n_q <= 4'd2;
			k_q <= '0;
			m_q <= '0;
			cc_q <= '0;
			oi_q <= '0;
			oj_q <= '0;
		end else begin
			oi_q <= nxt_i;
			oj_q <= nxt_j;
			unique case (st_q)
				S_IDLE: begin
					if (!q_empty) begin
						a_q[IW'(q_data.idx)] <= q_data.diag;
						if (!q_data.last) begin
							b_q[IW'(q_data.idx)] <= q_data.upper;
							c_q[IW'(q_data.idx)] <= q_data.lower;
						end else begin
							n_q <= q_data.size;
							sing_q <= 1'b0;
							ys_q[0] <= '0;
							xs_q[IW'(q_data.size - 4'd1)] <= '0;
							k_q <= 4'd1;
							st_q <= S_UP;
						end
					end
				end
				S_UP: st_q <= S_UPW;
				S_UPW: begin
					if (div_done) begin
						ur_q[IW'(k_q)] <= div_q;
						sing_q <= sing_q | div_zero;
						st_q <= S_UPM;
					end
				end
				S_UPM: begin
					ys_q[IW'(k_q)] <= mul_r;
					if (k_q + 4'd1 == n_q) begin
						k_q <= n_q - 4'd2;
						st_q <= S_DN;
					end else begin
						k_q <= k_q + 4'd1;
						st_q <= S_UP;
					end
				end
				S_DN: st_q <= S_DNW;
				S_DNW: begin
					if (div_done) begin
						dr_q[IW'(k_q)] <= div_q;
						sing_q <= sing_q | div_zero;
						st_q <= S_DNM;
					end
				end
				S_DNM: begin
					xs_q[IW'(k_q)] <= mul_r;
					if (k_q == 4'd0) begin
						st_q <= S_DG;
					end else begin
						k_q <= k_q - 4'd1;
						st_q <= S_DN;
					end
				end
				S_DG: st_q <= S_DGW;
				S_DGW: begin
					if (div_done) begin
						g_q[GW'({IW'(k_q), IW'(k_q)})] <= div_q;
						gd_q[IW'(k_q)] <= div_q;
						sing_q <= sing_q | div_zero;
						if (k_q + 4'd1 == n_q) begin
							cc_q <= '0;
							st_q <= S_CM;
						end else begin
							k_q <= k_q + 4'd1;
							st_q <= S_DG;
						end
					end
				end
				S_CM: begin
					// Start of one column: seed from its diagonal, go up first (column 0 goes straight down).
					prev_q <= gd_q[IW'(cc_q)];
					m_q <= cc_q;
					st_q <= (cc_q == 4'd0) ? S_CD : S_CU;
				end
				S_CU: begin
					g_q[GW'({IW'(m_q - 4'd1), IW'(cc_q)})] <= neg_r;
					if (m_q == 4'd1) begin
						prev_q <= gd_q[IW'(cc_q)];
						m_q <= cc_q;
						st_q <= S_CD;
					end else begin
						prev_q <= neg_r;
						m_q <= m_q - 4'd1;
					end
				end
				S_CD: begin
					if (m_q + 4'd1 >= n_q) begin
						if (cc_q + 4'd1 == n_q) begin
							st_q <= S_OUT;
						end else begin
							cc_q <= cc_q + 4'd1;
							st_q <= S_CM;
						end
					end else begin
						g_q[GW'({IW'(m_q + 4'd1), IW'(cc_q)})] <= neg_r;
						prev_q <= neg_r;
						m_q <= m_q + 4'd1;
					end
				end
				S_OUT: begin
					if (out_ready && ({1'b0, 4'(oj_q)} + 5'd1 == {1'b0, n_q})
							&& ({1'b0, 4'(oi_q)} + 5'd1 == {1'b0, n_q})) begin
						st_q <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ----- rtl/core/complex_tridiagonal_inverse.sv -----
// Complex tridiagonal inverter: loads rows, inverts on the last, streams the inverse.
// A non-final row is only stored; the final row starts 3n-2 divisions on the
// bit-serial divider plus n*(n+1) propagation steps, then the inverse is streamed.
// Throughput: n*n results, one per cycle while the sink is ready.
// Reset (arst_n, asynchronous) sets matrix_size to 5, row count to zero, and empties the queue.
module complex_tridiagonal_inverse #(
	parameter int MAX_SIZE = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [3:0] cfg_data,
	cti_row_if.sink    in_ch,
	cti_elem_if.source out_ch
);
	import cti_pkg::*;

	// The front tags each request with its row and whether it finishes the matrix.
	logic  push, q_full, q_empty, pop;
	task_t push_data, pop_data;

	cti_front #(.MAX_SIZE(MAX_SIZE)) u_front (
		.clk, .arst_n, .cfg_we, .cfg_data,
		.in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
		.push, .push_data, .q_full
	);

	// Queue lets new rows be taken while the back still streams the inverse.
	cti_queue u_queue (
		.clk, .arst_n, .push, .push_data, .full(q_full),
		.pop, .empty(q_empty), .pop_data
	);

	// The back stores rows and runs the sweeps through one shared divider.
	cti_back #(.MAX_SIZE(MAX_SIZE)) u_back (
		.clk, .arst_n, .q_empty, .q_data(pop_data), .pop,
		.out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
	);
endmodule

// ----- rtl/core/cti_checker.sv -----
// Port-level checker for the complex tridiagonal inverter, bound to the top level.
// Has no dependency on cti_pkg; its ports are plain signals of the output channel.
module cti_checker (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_ready,
	input logic last_result,
	input logic singular,
	input logic [2:0] row,
	input logic [2:0] col
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(row) && $stable(col))
		else $error("result dropped while stalled");
	a_sing: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_result |=> !out_valid || $stable(singular))
		else $error("singular changed within a matrix");
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_result |-> row == col)
		else $error("last element off the diagonal");
endmodule

bind complex_tridiagonal_inverse cti_checker u_cti_checker (
	.clk, .arst_n, .out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.last_result(out_ch.data.last_result), .singular(out_ch.data.singular),
	.row(out_ch.data.row), .col(out_ch.data.col)
);
